// File: hdl/trsm_pkg.sv
// Shared types and constants for the traffic rate saturation monitor.
package trsm_pkg;

    localparam int WIN_BITS    = 15;
    localparam int POLL_BITS   = 10;
    localparam int RATE_BITS   = 32;
    localparam int TOTAL_BITS  = 42;
    localparam int LEN_BITS    = 16;
    localparam int TS_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WIN_BITS-1:0]  WINDOW_MAX = 15'd18000;
    localparam logic [POLL_BITS-1:0] POLLS_MAX  = 10'd1000;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SECONDS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAT_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POLLS_NEEDED   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BURST_THRESHOLD = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input request taken this cycle
        logic start_div;  // launch the shared divider
        logic post_rate;  // window rate is ready: update polls, total, peak
        logic load_avg;   // average quotient is ready
        logic publish;    // move staged result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ovf;        // incoming packet would overflow the byte counter
        logic close;      // incoming packet closes the window
        logic div_done;   // divider finished
        logic sustained;  // poll count reaches the needed count
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// File: hdl/trsm_div.sv
// Restoring divider, one quotient bit per cycle, 15-bit divisor.
module trsm_div #(
    parameter int DIVIDEND_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVIDEND_BITS-1:0]      i_dividend,
    input  logic [trsm_pkg::WIN_BITS-1:0] i_divisor,
    output logic [DIVIDEND_BITS-1:0]      o_quotient,
    output logic                          o_done
);
    import trsm_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic [DIVIDEND_BITS-1:0] r_work;
    logic [WIN_BITS-1:0]      r_rem;
    logic [WIN_BITS-1:0]      r_div;
    logic [CNT_BITS-1:0]      r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [WIN_BITS:0] shifted;
    logic [WIN_BITS:0] diff;
    logic              ge;

    assign shifted = {r_rem, r_work[DIVIDEND_BITS-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DIVIDEND_BITS-2:0], ge};
            r_rem  <= ge ? diff[WIN_BITS-1:0] : shifted[WIN_BITS-1:0];
        end
    end

    assign o_quotient = r_work;
    assign o_done     = r_done;

endmodule

// File: hdl/trsm_dp.sv
// Datapath: window state, config registers, rate statistics and result registers.
module trsm_dp #(
    parameter int BYTE_COUNT_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trsm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [trsm_pkg::RATE_BITS-1:0]    i_cfg_data,
    input  logic [trsm_pkg::LEN_BITS-1:0]     i_packet_length,
    input  logic [trsm_pkg::TS_BITS-1:0]      i_timestamp_seconds,
    input  trsm_pkg::t_cmd                    i_cmd,
    output trsm_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_overflow_flag,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_window_rate,
    output logic [trsm_pkg::POLL_BITS-1:0]    o_saturated_polls,
    output logic                              o_sustained_alert,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_average_rate,
    output logic                              o_burst_alert,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_rate_peak
);
    import trsm_pkg::*;

    localparam int DIV_BITS = (BYTE_COUNT_BITS > TOTAL_BITS) ? BYTE_COUNT_BITS : TOTAL_BITS;

    // config
    logic [WIN_BITS-1:0]  r_win_cfg;
    logic [RATE_BITS-1:0] r_sat_thr;
    logic [POLL_BITS-1:0] r_polls_cfg;
    logic [RATE_BITS-1:0] r_burst_thr;

    // monitor state
    logic [BYTE_COUNT_BITS-1:0] r_bytes;
    logic [TS_BITS-1:0]         r_start;
    logic                       r_open;
    logic [POLL_BITS-1:0]       r_poll;
    logic [TOTAL_BITS-1:0]      r_total;
    logic [RATE_BITS-1:0]       r_peak;

    // staged result
    logic                 r_s_ovf;
    logic [RATE_BITS-1:0] r_s_rate;
    logic [POLL_BITS-1:0] r_s_polls;
    logic                 r_s_sust;
    logic [RATE_BITS-1:0] r_s_avg;
    logic                 r_s_burst;

    // output register
    logic                 r_o_valid;
    logic                 r_o_ovf;
    logic [RATE_BITS-1:0] r_o_rate;
    logic [POLL_BITS-1:0] r_o_polls;
    logic                 r_o_sust;
    logic [RATE_BITS-1:0] r_o_avg;
    logic                 r_o_burst;
    logic [RATE_BITS-1:0] r_o_peak;

    logic [WIN_BITS-1:0]        eff_win;
    logic [POLL_BITS-1:0]       eff_need;
    logic [TS_BITS-1:0]         cur_start;
    logic [BYTE_COUNT_BITS:0]   sum;
    logic [TS_BITS:0]           win_end;
    logic                       ovf;
    logic                       close;
    logic [DIV_BITS-1:0]        quot;
    logic                       div_done;
    logic [RATE_BITS-1:0]       q_sat;
    logic                       sat_hit;
    logic [POLL_BITS-1:0]       poll_inc;
    logic [TOTAL_BITS:0]        total_sum;
    logic [TOTAL_BITS-1:0]      total_new;
    logic                       sust;
    logic                       div_start;
    logic [DIV_BITS-1:0]        div_dividend;
    logic [WIN_BITS-1:0]        div_divisor;

    always_comb begin
        if (r_win_cfg == '0)
            eff_win = WIN_BITS'(1);
        else if (r_win_cfg > WINDOW_MAX)
            eff_win = WINDOW_MAX;
        else
            eff_win = r_win_cfg;
        if (r_polls_cfg == '0)
            eff_need = POLL_BITS'(1);
        else if (r_polls_cfg > POLLS_MAX)
            eff_need = POLLS_MAX;
        else
            eff_need = r_polls_cfg;
    end

    // first packet opens the window at its own timestamp
    assign cur_start = r_open ? r_start : i_timestamp_seconds;
    assign sum       = {1'b0, r_bytes} + (BYTE_COUNT_BITS + 1)'(i_packet_length);
    assign ovf       = sum[BYTE_COUNT_BITS];
    // window end kept at 33 bits so it never wraps
    assign win_end   = {1'b0, cur_start} + (TS_BITS + 1)'(eff_win);
    assign close     = !ovf && ({1'b0, i_timestamp_seconds} > win_end);

    assign q_sat     = (|quot[DIV_BITS-1:RATE_BITS]) ? '1 : quot[RATE_BITS-1:0];
    assign sat_hit   = q_sat >= r_sat_thr;
    assign poll_inc  = r_poll + 1'b1;
    assign total_sum = {1'b0, r_total} + (TOTAL_BITS + 1)'(q_sat);
    assign total_new = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
    assign sust      = sat_hit && (poll_inc >= eff_need);

    assign div_start    = i_cmd.start_div;
    assign div_dividend = i_cmd.post_rate ? DIV_BITS'(total_new)
                                          : DIV_BITS'(sum[BYTE_COUNT_BITS-1:0]);
    assign div_divisor  = i_cmd.post_rate ? WIN_BITS'(eff_need) : eff_win;

    trsm_div #(
        .DIVIDEND_BITS(DIV_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_quotient(quot),
        .o_done    (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg   <= WIN_BITS'(1);
            r_sat_thr   <= RATE_BITS'(1000000);
            r_polls_cfg <= POLL_BITS'(10);
            r_burst_thr <= RATE_BITS'(10000000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_SECONDS:  r_win_cfg   <= i_cfg_data[WIN_BITS-1:0];
                REG_SAT_THRESHOLD:   r_sat_thr   <= i_cfg_data;
                REG_POLLS_NEEDED:    r_polls_cfg <= i_cfg_data[POLL_BITS-1:0];
                REG_BURST_THRESHOLD: r_burst_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_start <= '0;
            r_open  <= 1'b0;
            r_poll  <= '0;
            r_total <= '0;
            r_peak  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_open  <= 1'b1;
                r_start <= close ? i_timestamp_seconds : cur_start;
                if (!ovf)
                    r_bytes <= close ? '0 : sum[BYTE_COUNT_BITS-1:0];
            end
            if (i_cmd.post_rate) begin
                if (sat_hit && !sust) begin
                    r_poll  <= poll_inc;
                    r_total <= total_new;
                end else begin
                    r_poll  <= '0;
                    r_total <= '0;
                end
                if (sat_hit && (q_sat > r_peak))
                    r_peak <= q_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && ovf) begin
            r_s_ovf   <= 1'b1;
            r_s_rate  <= '0;
            r_s_polls <= '0;
            r_s_sust  <= 1'b0;
            r_s_avg   <= '0;
            r_s_burst <= 1'b0;
        end
        if (i_cmd.post_rate) begin
            r_s_ovf   <= 1'b0;
            r_s_rate  <= q_sat;
            r_s_polls <= (sat_hit && !sust) ? poll_inc : '0;
            r_s_sust  <= sust;
            r_s_avg   <= '0;
            r_s_burst <= sat_hit && (q_sat >= r_burst_thr);
        end
        if (i_cmd.load_avg)
            r_s_avg <= q_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_ovf   <= r_s_ovf;
            r_o_rate  <= r_s_rate;
            r_o_polls <= r_s_polls;
            r_o_sust  <= r_s_sust;
            r_o_avg   <= r_s_avg;
            r_o_burst <= r_s_burst;
            r_o_peak  <= r_peak;
        end
    end

    assign o_sts.ovf       = ovf;
    assign o_sts.close     = close;
    assign o_sts.div_done  = div_done;
    assign o_sts.sustained = sust;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid       = r_o_valid;
    assign o_overflow_flag   = r_o_ovf;
    assign o_window_rate     = r_o_rate;
    assign o_saturated_polls = r_o_polls;
    assign o_sustained_alert = r_o_sust;
    assign o_average_rate    = r_o_avg;
    assign o_burst_alert     = r_o_burst;
    assign o_rate_peak       = r_o_peak;

    a_ovf_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_ovf |-> r_o_rate == '0 && !r_o_sust && !r_o_burst)
        else $error("overflow result carries window fields");

    a_sust_clears_polls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_sust |-> r_o_polls == '0)
        else $error("sustained alert with nonzero poll count");

    a_poll_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.post_rate |=> r_poll < eff_need || r_poll == '0)
        else $error("poll count left at or above needed count");

endmodule

// File: hdl/trsm_ctrl.sv
// Controller state machine: packet accept, divider sequencing and result publish.
module trsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  trsm_pkg::t_sts i_sts,
    output trsm_pkg::t_cmd o_cmd
);
    import trsm_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_RATE = 3'd1;
    localparam logic [2:0] ST_POST     = 3'd2;
    localparam logic [2:0] ST_DIV_AVG  = 3'd3;
    localparam logic [2:0] ST_PUBLISH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       take;

    assign o_in_ready = (r_state == ST_IDLE);
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.ovf) begin
                        n_state = ST_PUBLISH;
                    end else if (i_sts.close) begin
                        o_cmd.start_div = 1'b1;
                        n_state = ST_DIV_RATE;
                    end
                end
            end
            ST_DIV_RATE: begin
                if (i_sts.div_done)
                    n_state = ST_POST;
            end
            ST_POST: begin
                o_cmd.post_rate = 1'b1;
                if (i_sts.sustained) begin
                    o_cmd.start_div = 1'b1;
                    n_state = ST_DIV_AVG;
                end else begin
                    n_state = ST_PUBLISH;
                end
            end
            ST_DIV_AVG: begin
                if (i_sts.div_done) begin
                    o_cmd.load_avg = 1'b1;
                    n_state = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_sts.out_free)
        else $error("publish into a full output register");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV_RATE || r_state == ST_DIV_AVG))
        else $error("divider finished outside a divide state");

    a_start_goes_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_div |=> (r_state == ST_DIV_RATE || r_state == ST_DIV_AVG))
        else $error("divider started without waiting for it");

endmodule

// File: hdl/traffic_rate_saturation_monitor_top.sv
// A packet that closes no window is taken while the controller is idle and gives no result.
// An overflowing packet goes straight to the publish state; its result becomes valid once
// the output register is free. A closing packet runs the shared 1-bit-per-cycle divider
// (D = max(BYTE_COUNT_BITS, 42) bits) for the rate and again for a sustained alert's average.
// Throughput: one packet per cycle; closing and overflowing packets stall input until published.
// Reset (synchronous, active low) clears all monitor state and loads register defaults.
module traffic_rate_saturation_monitor_top #(
    parameter int BYTE_COUNT_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trsm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [trsm_pkg::RATE_BITS-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [trsm_pkg::LEN_BITS-1:0]     i_packet_length,
    input  logic [trsm_pkg::TS_BITS-1:0]      i_timestamp_seconds,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_overflow_flag,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_window_rate,
    output logic [trsm_pkg::POLL_BITS-1:0]    o_saturated_polls,
    output logic                              o_sustained_alert,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_average_rate,
    output logic                              o_burst_alert,
    output logic [trsm_pkg::RATE_BITS-1:0]    o_rate_peak
);
    import trsm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    trsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    trsm_dp #(
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_packet_length    (i_packet_length),
        .i_timestamp_seconds(i_timestamp_seconds),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_overflow_flag    (o_overflow_flag),
        .o_window_rate      (o_window_rate),
        .o_saturated_polls  (o_saturated_polls),
        .o_sustained_alert  (o_sustained_alert),
        .o_average_rate     (o_average_rate),
        .o_burst_alert      (o_burst_alert),
        .o_rate_peak        (o_rate_peak)
    );

endmodule
